// File: rtl/sbc_pkg.sv
package sbc_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 16;
  localparam int NUM_ROUNDS = 64;
  localparam int NUM_HASH   = 8;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sbc_state_t;

  localparam word_t INIT_HASH [NUM_HASH] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

endpackage

// File: rtl/sha256_block_compress_core.sv
// After the transaction that carries the sixteenth word of a final block, the core runs
// the 64 rounds and then the digest add before the first digest word is valid.
// Throughput: one word per cycle while a block loads; no new words are taken during
// the rounds and the add, nor while the eight digest words of a final block are output.
// Reset (rst, synchronous, active high) returns to word loading with the hash
// registers at the standard initial values and all counters at zero.
module sha256_block_compress_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] message_word,
  input  logic        first_block,
  input  logic        final_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);
  import sbc_pkg::*;

  // Control state.
  sbc_state_t state, state_next;
  logic [3:0] word_count;
  logic [5:0] round_count;
  logic [2:0] out_index;
  logic       final_flag;

  // Datapath state. The schedule window is a shift line: during the rounds,
  // tap 0 always holds W[t] and the newly expanded word enters at tap 15.
  word_t sched [NUM_WORDS];
  word_t hash  [NUM_HASH];
  word_t va, vb, vc, vd, ve, vf, vg, vh;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // The shared round unit: one SHA-256 round plus one schedule expansion step.
  word_t big_s1, ch, t1, big_s0, maj, t2, sig0, sig1, w_new;
  always_comb begin
    big_s1 = rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25);
    ch     = (ve & vf) ^ (~ve & vg);
    t1     = vh + big_s1 + ch + ROUND_K[round_count] + sched[0];
    big_s0 = rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22);
    maj    = (va & vb) ^ (va & vc) ^ (vb & vc);
    t2     = big_s0 + maj;
    sig0   = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    sig1   = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    w_new  = sched[0] + sig0 + sched[9] + sig1;
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && word_count == 4'd15) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_count == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = final_flag ? ST_OUT : ST_LOAD;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready && out_index == 3'd7) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count  <= '0;
      round_count <= '0;
      out_index   <= '0;
      final_flag  <= 1'b0;
    end else begin
      if (in_xfer) begin
        word_count <= word_count + 4'd1;
        if (word_count == 4'd15) begin
          final_flag <= final_block;
        end
      end
      if (state == ST_ROUND) begin
        round_count <= round_count + 6'd1;
      end
      if (out_xfer) begin
        out_index <= out_index + 3'd1;
      end
    end
  end

  // Hash registers: reloaded on the first word of a first block, accumulated
  // after the last round of every block.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HASH; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end else if (in_xfer && word_count == 4'd0 && first_block) begin
      for (int i = 0; i < NUM_HASH; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end else if (state == ST_ADD) begin
      hash[0] <= hash[0] + va;
      hash[1] <= hash[1] + vb;
      hash[2] <= hash[2] + vc;
      hash[3] <= hash[3] + vd;
      hash[4] <= hash[4] + ve;
      hash[5] <= hash[5] + vf;
      hash[6] <= hash[6] + vg;
      hash[7] <= hash[7] + vh;
    end
  end

  // Schedule window: words shift in as they arrive, expanded words shift in
  // during the rounds.
  always_ff @(posedge clk) begin
    if (in_xfer || state == ST_ROUND) begin
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[NUM_WORDS-1] <= in_xfer ? message_word : w_new;
    end
  end

  // Working variables. They are loaded from the hash registers when the last
  // word of a block arrives; a first-block reload at word zero has already
  // landed in the hash registers by then.
  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= '0;
    end else if (in_xfer && word_count == 4'd15) begin
      va <= hash[0];
      vb <= hash[1];
      vc <= hash[2];
      vd <= hash[3];
      ve <= hash[4];
      vf <= hash[5];
      vg <= hash[6];
      vh <= hash[7];
    end else if (state == ST_ROUND) begin
      vh <= vg;
      vg <= vf;
      vf <= ve;
      ve <= vd + t1;
      vd <= vc;
      vc <= vb;
      vb <= va;
      va <= t1 + t2;
    end
  end

  // Output payload comes straight from the hash registers, which hold still
  // while the digest is being emitted.
  assign digest_word = hash[out_index];
  assign word_index  = out_index;
  assign last        = (out_index == 3'd7);

endmodule

// File: rtl/sbc_checker.sv
module sbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("stalled digest word changed");

  // The block never takes input words while emitting a digest.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digest is output");

  // A digest run always starts at word zero.
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> word_index == 3'd0)
    else $error("digest run did not start at word zero");

  // Words follow in order without gaps.
  a_in_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && word_index == 3'($past(word_index) + 3'd1))
    else $error("digest words out of order");

  // The run ends after the word marked last.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("digest run did not end after last word");

endmodule

bind sha256_block_compress_core sbc_checker u_sbc_checker (.*);
